@@ rtl/rcsfr_pkg.sv @@
// Package for the RC serial frame receiver.
// Holds sizes, opcodes, register addresses and reset values, phase encoding and the result type; no dependencies.
package rcsfr_pkg;

   localparam int MAX_FRAME_LENGTH = 32;
   localparam int NUM_CHANNELS     = 14;
   localparam int MIN_FRAME_LENGTH = 4;
   localparam int FRAME_OVERHEAD   = 3;
   localparam int BUF_SIZE         = MAX_FRAME_LENGTH;

   localparam int IDX_W = $clog2(MAX_FRAME_LENGTH);
   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic [15:0] SUM_INIT = 16'hFFFF;

   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_GAP_MS  = 1'b0;
   localparam logic REG_COMMAND = 1'b1;

   localparam logic [7:0] GAP_MS_RESET  = 8'd3;
   localparam logic [7:0] COMMAND_RESET = 8'd64;

   typedef enum logic [4:0] {
      PH_DISCARD  = 5'b00001,
      PH_LENGTH   = 5'b00010,
      PH_DATA     = 5'b00100,
      PH_SUM_LOW  = 5'b01000,
      PH_SUM_HIGH = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [15:0] read_value;
      logic        frame_accepted;
      logic        checksum_failed;
   } result_type;

endpackage

@@ rtl/rcsfr_req_if.sv @@
// Request channel interface of the RC serial frame receiver.
// Carries valid, ready and one input transaction; uses rcsfr_pkg.
interface rcsfr_req_if
   import rcsfr_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] data_byte;
   logic [7:0] channel_number;

   modport source (output valid, output opcode, output data_byte, output channel_number,
                   input ready);
   modport sink   (input valid, input opcode, input data_byte, input channel_number,
                   output ready);
endinterface

@@ rtl/rcsfr_rsp_if.sv @@
// Response channel interface of the RC serial frame receiver.
// Carries valid, ready and one result transaction; uses rcsfr_pkg.
interface rcsfr_rsp_if
   import rcsfr_pkg::*;
   ();
   logic        valid;
   logic        ready;
   logic [15:0] read_value;
   logic        frame_accepted;
   logic        checksum_failed;

   modport source (output valid, output read_value, output frame_accepted,
                   output checksum_failed, input ready);
   modport sink   (input valid, input read_value, input frame_accepted,
                   input checksum_failed, output ready);
endinterface

@@ rtl/rc_serial_frame_receiver.sv @@
// Top level of the RC serial frame receiver: parser, frame buffer, channel store.
// Depends on rcsfr_pkg, rcsfr_req_if and rcsfr_rsp_if.
//
// Usage:
//   req carries one transaction per handshake: a received serial byte, a
//   one millisecond tick, or a channel read. Every transaction returns
//   exactly one result on rsp: the channel value for a read, and the
//   frame_accepted / checksum_failed flags for the byte that ends a frame.
//   gap_ms and command_code are written through the csr APB port at byte
//   addresses 0 and 4, by the user only while no transaction is in flight;
//   the block does not enforce this. Each result is registered at acceptance.
//   Throughput: one transaction per cycle while req.ready is high; the
//   parser state, frame buffer and channel store all update at the accepting edge.
//   Stall: a two-entry result buffer lets one more transaction in while a
//   result waits; with both entries full, req.ready drops until rsp.ready.
//   Reset: parser goes to discard (a gap is needed before the first frame),
//   idle count, frame buffer and channels clear, registers take 3 and 64.
module rc_serial_frame_receiver
   import rcsfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rcsfr_req_if.sink             req,
   rcsfr_rsp_if.source           rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [7:0]        gap_ms_ff;
   logic [7:0]        command_ff;

   phase_type         phase_ff, phase_in;
   logic [7:0]        idle_count_ff, idle_count_in;
   logic [IDX_W-1:0]  data_index_ff, data_index_in;
   logic [IDX_W-1:0]  data_length_ff, data_length_in;
   logic [15:0]       running_sum_ff, running_sum_in;
   logic [7:0]        sum_low_ff, sum_low_in;
   logic [7:0]        frame_bytes_ff [BUF_SIZE];
   logic [15:0]       channel_ff [NUM_CHANNELS];
   logic [15:0]       commit_value [NUM_CHANNELS];

   logic              buf_we;
   logic              commit;
   logic              accept;
   logic              pop;
   logic              gap_hit;
   phase_type         byte_phase;
   logic [IDX_W:0]    next_index;
   result_type        result;

   result_type        head_ff, skid_ff;
   logic              head_valid_ff, skid_valid_ff;

   // configuration port
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ms_ff  <= GAP_MS_RESET;
         command_ff <= COMMAND_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            REG_GAP_MS:  gap_ms_ff  <= csr_pwdata[7:0];
            REG_COMMAND: command_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_GAP_MS:  csr_prdata = {24'd0, gap_ms_ff};
         REG_COMMAND: csr_prdata = {24'd0, command_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   // handshake
   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && req.ready;
   assign pop       = head_valid_ff && rsp.ready;

   assign gap_hit    = idle_count_ff >= gap_ms_ff;
   assign byte_phase = gap_hit ? PH_LENGTH : phase_ff;
   assign next_index = {1'b0, data_index_ff} + (IDX_W+1)'(1);

   // channel values taken from the frame buffer on commit
   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         commit_value[ch] = 16'd0;
         if (1 + 2 * ch < BUF_SIZE) begin
            commit_value[ch][7:0] = frame_bytes_ff[IDX_W'(1 + 2 * ch)];
         end
         if (2 + 2 * ch < BUF_SIZE) begin
            commit_value[ch][15:8] = frame_bytes_ff[IDX_W'(2 + 2 * ch)];
         end
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      idle_count_in  = idle_count_ff;
      data_index_in  = data_index_ff;
      data_length_in = data_length_ff;
      running_sum_in = running_sum_ff;
      sum_low_in     = sum_low_ff;
      buf_we         = 1'b0;
      commit         = 1'b0;
      result         = '0;
      if (accept) begin
         unique case (req.opcode)
            OP_BYTE: begin
               idle_count_in = 8'd0;
               unique case (byte_phase)
                  PH_LENGTH: begin
                     if (req.data_byte <= 8'(MAX_FRAME_LENGTH) &&
                         req.data_byte >= 8'(MIN_FRAME_LENGTH)) begin
                        data_index_in  = '0;
                        data_length_in = IDX_W'(req.data_byte - 8'(FRAME_OVERHEAD));
                        running_sum_in = SUM_INIT - {8'd0, req.data_byte};
                        phase_in       = PH_DATA;
                     end else begin
                        phase_in = PH_DISCARD;
                     end
                  end
                  PH_DATA: begin
                     buf_we         = 1'b1;
                     data_index_in  = next_index[IDX_W-1:0];
                     running_sum_in = running_sum_ff - {8'd0, req.data_byte};
                     phase_in       = (next_index >= {1'b0, data_length_ff}) ?
                                      PH_SUM_LOW : PH_DATA;
                  end
                  PH_SUM_LOW: begin
                     sum_low_in = req.data_byte;
                     phase_in   = PH_SUM_HIGH;
                  end
                  PH_SUM_HIGH: begin
                     if (running_sum_ff == {req.data_byte, sum_low_ff}) begin
                        result.frame_accepted = 1'b1;
                        commit = (frame_bytes_ff[0] == command_ff);
                     end else begin
                        result.checksum_failed = 1'b1;
                     end
                     phase_in = PH_DISCARD;
                  end
                  default: phase_in = PH_DISCARD;
               endcase
            end
            OP_TICK: begin
               if (idle_count_ff != 8'hFF) begin
                  idle_count_in = idle_count_ff + 8'd1;
               end
            end
            OP_READ: begin
               if (req.channel_number < 8'(NUM_CHANNELS)) begin
                  result.read_value = channel_ff[req.channel_number[CH_W-1:0]];
               end
            end
            default: ;
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_DISCARD;
         idle_count_ff  <= 8'd0;
         data_index_ff  <= '0;
         data_length_ff <= '0;
         running_sum_ff <= 16'd0;
         sum_low_ff     <= 8'd0;
      end else begin
         phase_ff       <= phase_in;
         idle_count_ff  <= idle_count_in;
         data_index_ff  <= data_index_in;
         data_length_ff <= data_length_in;
         running_sum_ff <= running_sum_in;
         sum_low_ff     <= sum_low_in;
      end
   end

   // frame buffer and channel store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUF_SIZE; i++) begin
            frame_bytes_ff[i] <= 8'd0;
         end
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            channel_ff[ch] <= 16'd0;
         end
      end else begin
         if (buf_we) begin
            frame_bytes_ff[data_index_ff] <= req.data_byte;
         end
         if (commit) begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
               channel_ff[ch] <= commit_value[ch];
            end
         end
      end
   end

   // two-entry result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (pop) begin
               head_valid_ff <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept && head_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else if (accept) begin
            head_valid_ff <= 1'b1;
         end else if (pop) begin
            head_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            head_ff <= skid_ff;
         end
      end else if (accept && head_valid_ff && !pop) begin
         skid_ff <= result;
      end else if (accept) begin
         head_ff <= result;
      end
   end

   assign rsp.valid           = head_valid_ff;
   assign rsp.read_value      = head_ff.read_value;
   assign rsp.frame_accepted  = head_ff.frame_accepted;
   assign rsp.checksum_failed = head_ff.checksum_failed;

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry held without a head entry");

   a_data_index_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (data_index_ff < data_length_ff))
      else $error("data index reached frame length in data phase");

   a_byte_clears_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req.opcode == OP_BYTE) |=> (idle_count_ff == 8'd0))
      else $error("idle count not cleared by received byte");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp.ready) |=> (head_ff == $past(head_ff)))
      else $error("held result changed while stalled");

endmodule
